// ===== hdl/svbb_pkg.sv =====
// ----------------------------------------------------------------------------
// svbb_pkg
// Shared types, constants and a saturation helper for the skinned vertex
// bounding box block.
// ----------------------------------------------------------------------------
`default_nettype none

package svbb_pkg;

   // Request kinds carried on the request channel.
   localparam logic REQ_JOINT_WRITE = 1'b0;
   localparam logic REQ_VERTEX      = 1'b1;

   // Blend weights: Q1.16 inputs and a signed derived fourth weight.
   localparam int WeightW      = 17;
   localparam int BlendWeightW = 20;
   localparam int NumBones     = 4;
   localparam int BoneIdW      = 6;
   localparam logic signed [BlendWeightW-1:0] WeightOne = 20'sd65536;

   // Tag that travels with each matrix element read through the datapath.
   typedef struct packed {
      logic       valid;
      logic [1:0] axis;
      logic [1:0] bone;
      logic [1:0] col;
   } svbb_tag_type;

   typedef logic signed [31:0] coord_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic coord_type sat32(input logic signed [63:0] v);
      coord_type r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/skinned_vertex_bounding_box.sv =====
// ----------------------------------------------------------------------------
// skinned_vertex_bounding_box
// Joint matrix store plus skinned position blend that grows a bounding box.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req_ channel (valid/stall). A joint write
// stores one matrix element; a vertex request grows the box. Every request
// returns exactly one response on the rsp_ channel: the box after it.
// Joint writes and raw-mode vertices answer in the cycle after acceptance.
// A skinned vertex reads 48 matrix elements (4 bones, 3 rows, 4 columns)
// one per cycle through the read port of the matrix RAM, then drains the
// multiply pipeline; that RAM read port sets the rate. One request is in
// work at a time; the next is taken once the response slot is free or
// being taken. A stalled response holds and blocks new requests. The csr_
// port writes skinned_mode; the user must write it only while the block is
// idle, which the block does not enforce. Reset empties the box and clears
// the mode; matrix contents stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module skinned_vertex_bounding_box #(
   parameter int MAX_JOINTS = 64,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [5:0]  req_joint_index,
   input  wire logic [3:0]  req_element_index,
   input  wire logic signed [31:0] req_matrix_value,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic [23:0] req_bone_ids,
   input  wire logic [16:0] req_weight_zero,
   input  wire logic [16:0] req_weight_one,
   input  wire logic [16:0] req_weight_two,
   input  wire logic        req_first_vertex,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_box_valid,
   output logic signed [31:0] rsp_box_min_x,
   output logic signed [31:0] rsp_box_min_y,
   output logic signed [31:0] rsp_box_min_z,
   output logic signed [31:0] rsp_box_max_x,
   output logic signed [31:0] rsp_box_max_y,
   output logic signed [31:0] rsp_box_max_z
);

   localparam int JointW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int AddrW  = JointW + 4;
   localparam int Depth  = MAX_JOINTS * 16;
   localparam int BW     = svbb_pkg::BlendWeightW;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   // Clamp a bone id to the last joint.
   function automatic logic [JointW-1:0] clamp_id(input logic [5:0] id);
      logic [8:0] t;
      t = {3'b000, id};
      if (t >= 9'(MAX_JOINTS)) begin
         t = 9'(MAX_JOINTS - 1);
      end
      return t[JointW-1:0];
   endfunction

   logic [1:0]                 state_ff, state_in;
   logic                       mode_ff;
   logic                       req_accept, rsp_free;
   logic [1:0]                 axis_ff, bone_ff, col_ff;
   logic [JointW-1:0]          ids_ff [svbb_pkg::NumBones];
   logic signed [BW-1:0]       weight_ff [svbb_pkg::NumBones];
   svbb_pkg::coord_type        pos_ff [3];
   logic                       first_ff;
   logic                       pt_ready_ff;
   svbb_pkg::coord_type        min_ff [3], max_ff [3];
   logic                       nonempty_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_nonempty_ff;
   svbb_pkg::coord_type        rsp_min_ff [3], rsp_max_ff [3];
   logic                       commit, commit_vertex, commit_first;
   svbb_pkg::coord_type        commit_pt [3];
   svbb_pkg::coord_type        new_min [3], new_max [3];
   logic                       base_ne;
   logic                       wr_en;
   logic [AddrW-1:0]           wr_addr, rd_addr;
   logic [8:0]                 joint_wide;
   logic [31:0]                rd_data;
   svbb_pkg::svbb_tag_type     tag;
   logic                       blend_done;
   svbb_pkg::coord_type        blend_pt [3];
   logic                       last_step;
   logic signed [BW-1:0]       w0, w1, w2;

   // Request handshake: one request in work, response slot must be free.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !(state_ff == ST_IDLE && rsp_free);
   assign req_accept = req_valid && !req_stall;

   // Joint matrix write port.
   assign joint_wide = {3'b000, req_joint_index};
   assign wr_en      = req_accept && req_type == svbb_pkg::REQ_JOINT_WRITE
                       && joint_wide < 9'(MAX_JOINTS);
   assign wr_addr    = {joint_wide[JointW-1:0], req_element_index};
   assign rd_addr    = {ids_ff[bone_ff], axis_ff, col_ff};

   svbb_ram #(
      .WIDTH  (32),
      .DEPTH  (Depth),
      .ADDR_W (AddrW)
   ) u_matrix_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_matrix_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read sequencer tag: column fastest, then bone, then axis.
   assign tag.valid = (state_ff == ST_RUN);
   assign tag.axis  = axis_ff;
   assign tag.bone  = bone_ff;
   assign tag.col   = col_ff;
   assign last_step = axis_ff == 2'd2 && bone_ff == 2'd3 && col_ff == 2'd3;

   svbb_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag),
      .rd_data (rd_data),
      .pos     (pos_ff),
      .weight  (weight_ff),
      .done    (blend_done),
      .point   (blend_pt)
   );

   // Commit selection: immediate requests or the finished blend.
   always_comb begin
      commit        = 1'b0;
      commit_vertex = 1'b0;
      commit_first  = first_ff;
      commit_pt     = blend_pt;
      state_in      = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_type == svbb_pkg::REQ_VERTEX && mode_ff) begin
                  state_in = ST_RUN;
               end else begin
                  commit        = 1'b1;
                  commit_vertex = (req_type == svbb_pkg::REQ_VERTEX);
                  commit_first  = req_first_vertex;
                  commit_pt[0]  = req_pos_x;
                  commit_pt[1]  = req_pos_y;
                  commit_pt[2]  = req_pos_z;
               end
            end
         end
         ST_RUN: begin
            if (last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pt_ready_ff && rsp_free) begin
               commit        = 1'b1;
               commit_vertex = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Box growth for the committed point.
   always_comb begin
      base_ne = nonempty_ff && !commit_first;
      for (int a = 0; a < 3; a++) begin
         new_min[a] = commit_pt[a];
         new_max[a] = commit_pt[a];
         if (base_ne) begin
            new_min[a] = (commit_pt[a] < min_ff[a]) ? commit_pt[a] : min_ff[a];
            new_max[a] = (commit_pt[a] > max_ff[a]) ? commit_pt[a] : max_ff[a];
         end
      end
   end

   // Fourth weight is one minus the other three.
   assign w0 = BW'(req_weight_zero);
   assign w1 = BW'(req_weight_one);
   assign w2 = BW'(req_weight_two);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         axis_ff      <= 2'd0;
         bone_ff      <= 2'd0;
         col_ff       <= 2'd0;
         pt_ready_ff  <= 1'b0;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            min_ff[a] <= '0;
            max_ff[a] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         if (state_ff == ST_RUN) begin
            col_ff <= col_ff + 2'd1;
            if (col_ff == 2'd3) begin
               bone_ff <= bone_ff + 2'd1;
               if (bone_ff == 2'd3) begin
                  axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
               end
            end
         end
         if (blend_done) begin
            pt_ready_ff <= 1'b1;
         end else if (commit) begin
            pt_ready_ff <= 1'b0;
         end
         if (commit && commit_vertex) begin
            nonempty_ff <= 1'b1;
            min_ff      <= new_min;
            max_ff      <= new_max;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Latched vertex operands and response payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pos_ff[0]    <= req_pos_x;
         pos_ff[1]    <= req_pos_y;
         pos_ff[2]    <= req_pos_z;
         first_ff     <= req_first_vertex;
         weight_ff[0] <= w0;
         weight_ff[1] <= w1;
         weight_ff[2] <= w2;
         weight_ff[3] <= svbb_pkg::WeightOne - w0 - w1 - w2;
         for (int b = 0; b < svbb_pkg::NumBones; b++) begin
            ids_ff[b] <= clamp_id(req_bone_ids[b*svbb_pkg::BoneIdW +: svbb_pkg::BoneIdW]);
         end
      end
      if (commit) begin
         if (commit_vertex) begin
            rsp_nonempty_ff <= 1'b1;
            rsp_min_ff      <= new_min;
            rsp_max_ff      <= new_max;
         end else begin
            rsp_nonempty_ff <= nonempty_ff;
            rsp_min_ff      <= min_ff;
            rsp_max_ff      <= max_ff;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_box_valid = rsp_nonempty_ff;
   assign rsp_box_min_x = rsp_min_ff[0];
   assign rsp_box_min_y = rsp_min_ff[1];
   assign rsp_box_min_z = rsp_min_ff[2];
   assign rsp_box_max_x = rsp_max_ff[0];
   assign rsp_box_max_y = rsp_max_ff[1];
   assign rsp_box_max_z = rsp_max_ff[2];

endmodule

`default_nettype wire

// ===== hdl/svbb_ram.sv =====
// ----------------------------------------------------------------------------
// svbb_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module svbb_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/svbb_blend.sv =====
// ----------------------------------------------------------------------------
// svbb_blend
// Pipelined skinning datapath. Takes one matrix element per cycle, forms the
// row dot products, weights each row by its bone and sums the bones per axis.
// ----------------------------------------------------------------------------
`default_nettype none

module svbb_blend #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire svbb_pkg::svbb_tag_type       tag_in,
   input  wire logic [31:0]                  rd_data,
   input  wire svbb_pkg::coord_type          pos [3],
   input  wire logic signed [svbb_pkg::BlendWeightW-1:0] weight [svbb_pkg::NumBones],
   output logic                              done,
   output svbb_pkg::coord_type               point [3]
);

   localparam logic signed [31:0] PointOne = 32'(64'd1 << FRAC_BITS);
   localparam int WProdW = 32 + svbb_pkg::BlendWeightW;

   svbb_pkg::svbb_tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic signed [63:0]     prod_ff;
   logic signed [33:0]     row_acc_ff;
   logic signed [33:0]     row_sum;
   svbb_pkg::coord_type    term;
   svbb_pkg::coord_type    row_ff;
   logic signed [31:0]     pc;
   logic signed [WProdW-1:0] wprod_ff;
   logic signed [WProdW-1:0] wshift;
   logic signed [63:0]     wshift_ext;
   svbb_pkg::coord_type    wterm;
   logic signed [33:0]     axis_acc_ff;
   logic signed [33:0]     axis_sum;
   svbb_pkg::coord_type    point_ff [3];
   logic                   done_ff;

   // Tag pipeline follows the data one stage at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= (tag2_ff.valid && tag2_ff.col == 2'd3) ? tag2_ff : '0;
         tag4_ff <= tag3_ff;
         done_ff <= tag4_ff.valid && tag4_ff.bone == 2'd3 && tag4_ff.axis == 2'd2;
      end
   end

   // Point coordinate for the element column; the fourth is one.
   always_comb begin
      case (tag1_ff.col)
         2'd0:    pc = pos[0];
         2'd1:    pc = pos[1];
         2'd2:    pc = pos[2];
         default: pc = PointOne;
      endcase
   end

   // Row term, row sum and weighted bone term.
   always_comb begin
      term       = svbb_pkg::sat32(prod_ff >>> FRAC_BITS);
      row_sum    = ((tag2_ff.col == 2'd0) ? 34'sd0 : row_acc_ff)
                   + {{2{term[31]}}, term};
      wshift     = wprod_ff >>> 16;
      wshift_ext = {{(64 - WProdW){wshift[WProdW-1]}}, wshift};
      wterm      = svbb_pkg::sat32(wshift_ext);
      axis_sum   = ((tag4_ff.bone == 2'd0) ? 34'sd0 : axis_acc_ff)
                   + {{2{wterm[31]}}, wterm};
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= signed'(rd_data) * pc;
      if (tag2_ff.valid) begin
         row_acc_ff <= row_sum;
         if (tag2_ff.col == 2'd3) begin
            row_ff <= svbb_pkg::sat32({{30{row_sum[33]}}, row_sum});
         end
      end
      wprod_ff <= row_ff * weight[tag3_ff.bone];
      if (tag4_ff.valid) begin
         axis_acc_ff <= axis_sum;
         if (tag4_ff.bone == 2'd3) begin
            point_ff[tag4_ff.axis] <= svbb_pkg::sat32({{30{axis_sum[33]}}, axis_sum});
         end
      end
   end

   assign done  = done_ff;
   assign point = point_ff;

endmodule

`default_nettype wire

// ===== tb/svbb_checker.sv =====
// ----------------------------------------------------------------------------
// svbb_checker
// Watches the request and response channels of the skinned vertex bounding
// box, predicts the box after each accepted request and compares it with
// each accepted response.
// ----------------------------------------------------------------------------
`default_nettype none

module svbb_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_type,
   input  wire logic [5:0]  req_joint_index,
   input  wire logic [3:0]  req_element_index,
   input  wire logic signed [31:0] req_matrix_value,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic [23:0] req_bone_ids,
   input  wire logic [16:0] req_weight_zero,
   input  wire logic [16:0] req_weight_one,
   input  wire logic [16:0] req_weight_two,
   input  wire logic        req_first_vertex,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_box_valid,
   input  wire logic signed [31:0] rsp_box_min_x,
   input  wire logic signed [31:0] rsp_box_min_y,
   input  wire logic signed [31:0] rsp_box_min_z,
   input  wire logic signed [31:0] rsp_box_max_x,
   input  wire logic signed [31:0] rsp_box_max_y,
   input  wire logic signed [31:0] rsp_box_max_z,
   output int               fail_count,
   output int               pending_boxes
);

   localparam int Joints    = 64;
   localparam int Frac      = 16;
   localparam int FifoDepth = 8;

   typedef struct packed {
      logic                nonempty;
      svbb_pkg::coord_type min_x, min_y, min_z, max_x, max_y, max_z;
   } box_type;

   // Predictor state.
   svbb_pkg::coord_type joint_mem [Joints*16];
   svbb_pkg::coord_type bounds [6];
   logic                box_full;
   logic                blend_on;

   // Expected boxes in request order.
   box_type    box_fifo [FifoDepth];
   logic [2:0] rd_ptr, wr_ptr;
   int         fifo_count;

   // Clamp to signed 32 bits.
   function automatic svbb_pkg::coord_type clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return svbb_pkg::coord_type'(v);
   endfunction

   // One row of one joint matrix applied to the homogeneous point.
   function automatic svbb_pkg::coord_type joint_row(input int joint, input int row,
                                                     input longint p [4]);
      longint acc;
      acc = 0;
      for (int c = 0; c < 4; c++) begin
         acc += clamp32((longint'(joint_mem[joint*16 + row*4 + c]) * p[c]) >>> Frac);
      end
      return clamp32(acc);
   endfunction

   // Work out the box after one request.
   function automatic box_type next_box(input logic kind, input logic [5:0] ji,
                                        input logic [3:0] ei,
                                        input svbb_pkg::coord_type mv,
                                        input svbb_pkg::coord_type px,
                                        input svbb_pkg::coord_type py,
                                        input svbb_pkg::coord_type pz,
                                        input logic [23:0] ids,
                                        input logic [16:0] w0, input logic [16:0] w1,
                                        input logic [16:0] w2, input logic first);
      svbb_pkg::coord_type pt [3];
      longint              p [4];
      longint              w [4];
      int                  bone [4];
      longint              acc;
      box_type             b;
      if (kind == svbb_pkg::REQ_JOINT_WRITE) begin
         joint_mem[int'(ji)*16 + int'(ei)] = mv;
      end else begin
         if (first) begin
            foreach (bounds[i]) bounds[i] = '0;
            box_full = 1'b0;
         end
         if (blend_on) begin
            p[0] = longint'(px); p[1] = longint'(py); p[2] = longint'(pz);
            p[3] = longint'(1) << Frac;
            w[0] = longint'(w0); w[1] = longint'(w1); w[2] = longint'(w2);
            w[3] = 65536 - w[0] - w[1] - w[2];
            for (int k = 0; k < 4; k++) begin
               bone[k] = int'(ids[6*k +: 6]);
               if (bone[k] >= Joints) bone[k] = Joints - 1;
            end
            for (int a = 0; a < 3; a++) begin
               acc = 0;
               for (int k = 0; k < 4; k++) begin
                  acc += clamp32((longint'(joint_row(bone[k], a, p)) * w[k]) >>> 16);
               end
               pt[a] = clamp32(acc);
            end
         end else begin
            pt[0] = px; pt[1] = py; pt[2] = pz;
         end
         for (int a = 0; a < 3; a++) begin
            if (!box_full || pt[a] < bounds[a]) bounds[a] = pt[a];
            if (!box_full || pt[a] > bounds[a+3]) bounds[a+3] = pt[a];
         end
         box_full = 1'b1;
      end
      b.nonempty = box_full;
      b.min_x = box_full ? bounds[0] : '0;
      b.min_y = box_full ? bounds[1] : '0;
      b.min_z = box_full ? bounds[2] : '0;
      b.max_x = box_full ? bounds[3] : '0;
      b.max_y = box_full ? bounds[4] : '0;
      b.max_z = box_full ? bounds[5] : '0;
      return b;
   endfunction

   task automatic compare_field(input string name, input svbb_pkg::coord_type want,
                                input svbb_pkg::coord_type got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   assign pending_boxes = fifo_count;

   // Predict on each accepted request and check each accepted response.
   always @(posedge clock) begin
      box_type want;
      box_type predicted;
      if (reset) begin
         foreach (bounds[i]) bounds[i] = '0;
         box_full = 1'b0;
         blend_on = 1'b0;
         fail_count = 0;
         rd_ptr = '0;
         wr_ptr = '0;
         fifo_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (fifo_count == 0) begin
               $error("response with no request waiting");
               fail_count++;
            end else begin
               want = box_fifo[rd_ptr];
               rd_ptr = rd_ptr + 3'd1;
               fifo_count--;
               if (want.nonempty !== rsp_box_valid) begin
                  $error("box_valid expected %0d actual %0d", want.nonempty,
                         rsp_box_valid);
                  fail_count++;
               end
               compare_field("box_min_x", want.min_x, rsp_box_min_x);
               compare_field("box_min_y", want.min_y, rsp_box_min_y);
               compare_field("box_min_z", want.min_z, rsp_box_min_z);
               compare_field("box_max_x", want.max_x, rsp_box_max_x);
               compare_field("box_max_y", want.max_y, rsp_box_max_y);
               compare_field("box_max_z", want.max_z, rsp_box_max_z);
            end
         end
         if (req_valid && !req_stall) begin
            predicted = next_box(req_type, req_joint_index,
               req_element_index, req_matrix_value, req_pos_x, req_pos_y,
               req_pos_z, req_bone_ids, req_weight_zero, req_weight_one,
               req_weight_two, req_first_vertex);
            if (fifo_count == FifoDepth) begin
               $error("too many requests waiting for a response");
               fail_count++;
            end else begin
               box_fifo[wr_ptr] = predicted;
               wr_ptr = wr_ptr + 3'd1;
               fifo_count++;
            end
         end
         if (csr_write_enable) blend_on = csr_write_data;
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the skinned vertex bounding box: loads joint
// matrices, sends raw and skinned vertices in both modes with random gaps
// and response stalls, and lets the checker compare every box.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int WatchdogLimit = 20000;

   logic clock;
   logic reset;
   logic csr_write_enable, csr_write_data;
   logic req_valid, req_stall, req_type;
   logic [5:0]  req_joint_index;
   logic [3:0]  req_element_index;
   logic signed [31:0] req_matrix_value, req_pos_x, req_pos_y, req_pos_z;
   logic [23:0] req_bone_ids;
   logic [16:0] req_weight_zero, req_weight_one, req_weight_two;
   logic        req_first_vertex;
   logic        rsp_valid, rsp_stall, rsp_box_valid;
   logic signed [31:0] rsp_box_min_x, rsp_box_min_y, rsp_box_min_z;
   logic signed [31:0] rsp_box_max_x, rsp_box_max_y, rsp_box_max_z;
   int          fail_count, pending_boxes;
   int          idle_cycles;
   int          vertex_count, joint_count;
   logic        stall_enabled;

   skinned_vertex_bounding_box DUT (.*);
   svbb_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length: mostly short, sometimes long, sometimes none.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Random response stalls, with stretches where they are off.
   always @(negedge clock) begin
      if (reset || !stall_enabled) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < 30);
   end

   // Watchdog on cycles in which nothing is accepted.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("FAIL skinned_vertex_bounding_box");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request and hold it until accepted.
   task automatic send_request(input logic kind, input logic [5:0] ji,
                               input logic [3:0] ei, input logic [31:0] mv,
                               input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] pz, input logic [23:0] ids,
                               input logic [16:0] w0, input logic [16:0] w1,
                               input logic [16:0] w2, input logic first);
      int gap;
      gap = gap_len();
      repeat (gap) @(negedge clock);
      req_valid = 1'b1;
      req_type = kind; req_joint_index = ji; req_element_index = ei;
      req_matrix_value = mv; req_pos_x = px; req_pos_y = py; req_pos_z = pz;
      req_bone_ids = ids; req_weight_zero = w0; req_weight_one = w1;
      req_weight_two = w2; req_first_vertex = first;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
      req_valid = 1'b0;
      if (kind == svbb_pkg::REQ_VERTEX) vertex_count++;
      else joint_count++;
   endtask

   task automatic write_joint(input logic [5:0] ji, input logic [3:0] ei,
                              input logic [31:0] mv);
      send_request(svbb_pkg::REQ_JOINT_WRITE, ji, ei, mv, $urandom, $urandom,
                   $urandom, 24'($urandom), 17'($urandom), 17'($urandom),
                   17'($urandom), 1'($urandom));
   endtask

   task automatic send_vertex(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic [23:0] ids,
                              input logic [16:0] w0, input logic [16:0] w1,
                              input logic [16:0] w2, input logic first);
      send_request(svbb_pkg::REQ_VERTEX, 6'($urandom), 4'($urandom), $urandom,
                   px, py, pz, ids, w0, w1, w2, first);
   endtask

   // Wait for every expected box, plus slack for the skinned pipeline.
   task automatic drain();
      while (pending_boxes != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic set_mode(input logic mode);
      drain();
      csr_write_enable = 1'b1;
      csr_write_data = mode;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Random value biased toward extremes, or small numbers near zero.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2, 3: return $urandom;
         default: return $signed($urandom_range(0, 2000000)) - 1000000;
      endcase
   endfunction

   function automatic logic [16:0] rand_weight();
      case ($urandom_range(0, 7))
         0: return 17'd65536;
         1: return 17'h1ffff;
         2: return 17'd0;
         default: return 17'($urandom_range(0, 30000));
      endcase
   endfunction

   // Bone ids from written joints only; id 63 appears as itself.
   function automatic logic [23:0] rand_bones();
      logic [23:0] ids;
      for (int k = 0; k < 4; k++) ids[6*k +: 6] = 6'($urandom_range(60, 63));
      return ids;
   endfunction

   initial begin
      logic [31:0] v;
      reset = 1'b1;
      stall_enabled = 1'b0;
      csr_write_enable = 1'b0; csr_write_data = 1'b0;
      req_valid = 1'b0; req_type = svbb_pkg::REQ_JOINT_WRITE;
      req_joint_index = '0; req_element_index = '0; req_matrix_value = '0;
      req_pos_x = '0; req_pos_y = '0; req_pos_z = '0; req_bone_ids = '0;
      req_weight_zero = '0; req_weight_one = '0; req_weight_two = '0;
      req_first_vertex = 1'b0;
      vertex_count = 0; joint_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed raw mode: extremes, empty box, first vertex flag.
      write_joint(6'd0, 4'd0, 32'h0);
      send_vertex(32'h7fffffff, 32'h80000000, 32'h0, '1, '1, '1, '1, 1'b0);
      send_vertex(32'h80000000, 32'h7fffffff, 32'hffffffff, '0, '0, '0, '0, 1'b0);
      send_vertex(32'h12345, 32'hfffe0000, 32'h1, '1, '1, '1, '1, 1'b1);
      send_vertex(32'h0, 32'h0, 32'h0, '0, '0, '0, '0, 1'b0);

      // Load joints 60..63: identity with a random translation, some extremes.
      for (int j = 60; j < 64; j++) begin
         for (int e = 0; e < 16; e++) begin
            if (e == 0 || e == 5 || e == 10 || e == 15) v = 32'h10000;
            else if (e < 12 && (e % 4) == 3) v = $signed($urandom_range(0, 400000)) - 200000;
            else v = 32'h0;
            if (j == 63 && e == 1) v = 32'h7fffffff;
            if (j == 62 && e == 2) v = 32'h80000000;
            write_joint(j[5:0], e[3:0], v);
         end
      end

      // Directed skinned vertices: weights above one, negative fourth weight.
      set_mode(1'b1);
      send_vertex(32'h10000, 32'h20000, 32'hfffd0000, 24'hfbefbf, 17'd65536,
                  17'd0, 17'd0, 1'b1);
      send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 24'hffffff,
                  17'h1ffff, 17'h1ffff, 17'h1ffff, 1'b0);
      send_vertex(32'h80000000, 32'h7fffffff, 32'h0, 24'hf3ef7c, 17'd16384,
                  17'd16384, 17'd16384, 1'b0);
      send_vertex(32'h0, 32'h0, 32'h0, 24'hfbefbf, 17'd0, 17'd0, 17'd0, 1'b1);

      // The sender holds until every box is back.
      drain();

      // Random phases alternating between modes, with mode extremes each time.
      stall_enabled = 1'b1;
      for (int phase = 0; phase < 6; phase++) begin
         set_mode(phase[0]);
         if (phase == 4) stall_enabled = 1'b0;
         for (int n = 0; n < 170; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               // Writes go anywhere; joints outside 60..63 are never read.
               write_joint(6'($urandom), 4'($urandom), $urandom);
            end else begin
               send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_bones(),
                           rand_weight(), rand_weight(), rand_weight(),
                           $urandom_range(0, 15) == 0);
            end
         end
         if (phase == 5) stall_enabled = 1'b1;
      end

      drain();
      $display("Covered %0d vertices and %0d joint writes in raw and skinned modes,",
               vertex_count, joint_count);
      $display("with random request gaps and response stalls.");
      if (fail_count == 0) begin
         $display("PASS skinned_vertex_bounding_box");
      end else begin
         $display("FAIL skinned_vertex_bounding_box");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/svbb_pkg.sv
hdl/svbb_ram.sv
hdl/svbb_blend.sv
hdl/skinned_vertex_bounding_box.sv
tb/svbb_checker.sv
tb/tb.sv
